// ===== rtl/core/abc_pkg.sv =====
// types, codes and constants shared by the alarm button controller
`default_nettype none

package abc_pkg;

    typedef enum logic [1:0] {
        MODE_CLOCK = 2'd0,
        MODE_TUNE  = 2'd1,
        MODE_ALARM = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } press_t;

    localparam logic [1:0] BTN_USER  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;
    localparam logic [1:0] BTN_NONE  = 2'd3;

    localparam logic REQ_BUTTON = 1'b0;
    localparam logic REQ_ALARM  = 1'b1;

    localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] CFG_SHORT_SNOOZE = 2'd2;
    localparam logic [1:0] CFG_LONG_SNOOZE  = 2'd3;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd250;
    localparam logic [31:0] SHORT_SNOOZE_RST = 32'd300000;
    localparam logic [31:0] LONG_SNOOZE_RST  = 32'd600000;
    localparam logic [31:0] ALARM_TIME_RST   = 32'd500000000;

    localparam logic [31:0] MINUTE_MS = 32'd60000;
    localparam logic [31:0] HOUR_MS   = 32'd3600000;

    localparam int NUM_BUTTONS = 3;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  which_button;
        logic        rising;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        mode_t       mode;
        logic        hour_select;
        logic [31:0] alarm_ms;
        press_t      press_kind;
        logic [1:0]  press_button;
        logic        stop_alarm;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/alarm_button_controller.sv =====
// alarm clock button controller: debounce, press classing and mode machine
// an accepted request is held in the input register, and its result in the result register
// throughput: one request per cycle while m_ready is high, set by the single input-to-result stage
// the result register frees as soon as m_ready takes it, so no bubbles
// reset (aresetn low, synchronous): clock mode, minute field, buttons released,
// alarm time 500000000 ms, configuration registers at their default values
`default_nettype none

module alarm_button_controller
    import abc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire req_t        s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output rsp_t             m_data
);

    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [31:0] short_snooze_reg;
    logic [31:0] long_snooze_reg;

    logic        in_valid_reg;
    req_t        in_data_reg;
    logic        out_valid_reg;
    rsp_t        out_data_reg;

    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [31:0] last_edge_reg [NUM_BUTTONS];
    logic [31:0] last_edge_next [NUM_BUTTONS];
    logic [31:0] press_start_reg [NUM_BUTTONS];
    logic [31:0] press_start_next [NUM_BUTTONS];
    mode_t       mode_reg, mode_next;
    logic        hour_reg, hour_next;
    logic [31:0] alarm_reg, alarm_next;

    logic        out_free;
    logic        advance;
    rsp_t        rsp_next;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        logic [1:0]  btn;
        logic        open;
        logic        lng;
        logic        clear;
        logic [31:0] delta;
        logic [31:0] last_sel;
        logic [31:0] start_sel;
        press_t      kind;
        logic [1:0]  pbtn;
        logic        stop;

        btn       = in_data_reg.which_button;
        held_next = held_reg;
        last_edge_next   = last_edge_reg;
        press_start_next = press_start_reg;
        mode_next = mode_reg;
        hour_next = hour_reg;
        clear     = 1'b0;
        delta     = 32'd0;
        kind      = PRESS_NONE;
        pbtn      = BTN_USER;
        stop      = 1'b0;
        lng       = 1'b0;

        case (btn)
            BTN_LEFT: begin
                last_sel  = last_edge_reg[1];
                start_sel = press_start_reg[1];
            end
            BTN_RIGHT: begin
                last_sel  = last_edge_reg[2];
                start_sel = press_start_reg[2];
            end
            default: begin
                last_sel  = last_edge_reg[0];
                start_sel = press_start_reg[0];
            end
        endcase

        open = (in_data_reg.now_ms - last_sel) > {16'd0, debounce_reg};

        if (in_data_reg.req_type == REQ_ALARM) begin
            mode_next = MODE_ALARM;
        end else if (btn != BTN_NONE) begin
            if (!held_reg[btn]) begin
                if (in_data_reg.rising && open) begin
                    held_next[btn]        = 1'b1;
                    last_edge_next[btn]   = in_data_reg.now_ms;
                    press_start_next[btn] = in_data_reg.now_ms;
                end
            end else if (!in_data_reg.rising && open) begin
                lng  = (in_data_reg.now_ms - start_sel) > {16'd0, long_press_reg};
                kind = lng ? PRESS_LONG : PRESS_SHORT;
                pbtn = btn;
                held_next[btn]        = 1'b0;
                last_edge_next[btn]   = in_data_reg.now_ms;
                press_start_next[btn] = 32'd0;
                case (mode_reg)
                    MODE_TUNE: begin
                        if (btn == BTN_USER) begin
                            if (lng) begin
                                mode_next = MODE_CLOCK;
                            end
                        end else if (!hour_reg) begin
                            if (btn == BTN_LEFT && lng) begin
                                hour_next = 1'b1;
                            end else if (btn == BTN_LEFT) begin
                                delta = 32'd0 - MINUTE_MS;
                            end else if (!lng) begin
                                delta = MINUTE_MS;
                            end
                        end else begin
                            if (btn == BTN_RIGHT && lng) begin
                                hour_next = 1'b0;
                            end else if (btn == BTN_LEFT && !lng) begin
                                delta = 32'd0 - HOUR_MS;
                            end else if (btn == BTN_RIGHT && !lng) begin
                                delta = HOUR_MS;
                            end
                        end
                    end
                    MODE_ALARM: begin
                        stop = 1'b1;
                        if (!lng) begin
                            if (btn == BTN_LEFT) begin
                                delta = short_snooze_reg;
                            end else if (btn == BTN_RIGHT) begin
                                delta = long_snooze_reg;
                            end
                            mode_next = MODE_CLOCK;
                        end
                    end
                    default: begin
                        if (btn == BTN_USER && lng) begin
                            clear     = 1'b1;
                            mode_next = MODE_TUNE;
                        end else begin
                            mode_next = MODE_CLOCK;
                        end
                    end
                endcase
            end
        end

        alarm_next = clear ? 32'd0 : alarm_reg + delta;

        rsp_next.mode         = mode_next;
        rsp_next.hour_select  = hour_next;
        rsp_next.alarm_ms     = alarm_next;
        rsp_next.press_kind   = kind;
        rsp_next.press_button = pbtn;
        rsp_next.stop_alarm   = stop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RST;
            long_press_reg   <= LONG_PRESS_RST;
            short_snooze_reg <= SHORT_SNOOZE_RST;
            long_snooze_reg  <= LONG_SNOOZE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE:     debounce_reg     <= cfg_wdata[15:0];
                CFG_LONG_PRESS:   long_press_reg   <= cfg_wdata[15:0];
                CFG_SHORT_SNOOZE: short_snooze_reg <= cfg_wdata;
                CFG_LONG_SNOOZE:  long_snooze_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            last_edge_reg   <= '{default: 32'd0};
            press_start_reg <= '{default: 32'd0};
            mode_reg      <= MODE_CLOCK;
            hour_reg      <= 1'b0;
            alarm_reg     <= ALARM_TIME_RST;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                held_reg        <= held_next;
                last_edge_reg   <= last_edge_next;
                press_start_reg <= press_start_next;
                mode_reg        <= mode_next;
                hour_reg        <= hour_next;
                alarm_reg       <= alarm_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= rsp_next;
        end
    end

    a_stop_has_press: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.stop_alarm |-> out_data_reg.press_kind != PRESS_NONE)
        else $error("stop without a recognized press");

    a_no_press_no_button: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.press_kind == PRESS_NONE
            |-> out_data_reg.press_button == BTN_USER)
        else $error("press button set without a press");

    a_long_stop_keeps_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.stop_alarm && out_data_reg.press_kind == PRESS_LONG
            |-> out_data_reg.mode == MODE_ALARM)
        else $error("long press in alarm mode left alarm mode");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a stalled request");

    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_data_reg.alarm_ms == alarm_reg && out_data_reg.mode == mode_reg)
        else $error("result differs from updated state");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the alarm clock button controller
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import abc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 80;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_DEBOUNCE;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsp_t        m_data;

    alarm_button_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // predictor state and register copies
    logic [15:0] debounce_cfg = DEBOUNCE_RST;
    logic [15:0] long_cfg = LONG_PRESS_RST;
    logic [31:0] short_snooze_cfg = SHORT_SNOOZE_RST;
    logic [31:0] long_snooze_cfg = LONG_SNOOZE_RST;
    logic        btn_held [NUM_BUTTONS] = '{default: 1'b0};
    logic [31:0] last_edge [NUM_BUTTONS] = '{default: 32'd0};
    logic [31:0] press_t0 [NUM_BUTTONS] = '{default: 32'd0};
    mode_t       cur_mode = MODE_CLOCK;
    logic        tune_hr = 1'b0;
    logic [31:0] alarm_at = ALARM_TIME_RST;

    req_t        event_queue [$];
    rsp_t        panel_due [$];
    logic [31:0] ms_clock = 32'd1000;
    int          items_queued = 0;
    int          results_seen = 0;
    int          short_seen = 0;
    int          long_seen = 0;
    int          stop_seen = 0;
    int          settings_count = 0;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          send_gap = 0;
    int          hold_cnt = 0;
    int          quiet = 0;
    logic        long_hold_req = 1'b0;
    logic        req_taken = 1'b0;
    rsp_t        want;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic rsp_t expected_panel(input req_t r);
        rsp_t        p;
        logic [1:0]  b;
        logic [31:0] since;
        logic        lng;
        p = '0;
        p.press_kind = PRESS_NONE;
        if (r.req_type == REQ_ALARM) begin
            cur_mode = MODE_ALARM;
        end else if (r.which_button != BTN_NONE) begin
            b = r.which_button;
            since = r.now_ms - last_edge[b];
            if (!btn_held[b]) begin
                if (r.rising && since > {16'd0, debounce_cfg}) begin
                    btn_held[b] = 1'b1;
                    last_edge[b] = r.now_ms;
                    press_t0[b] = r.now_ms;
                end
            end else if (!r.rising && since > {16'd0, debounce_cfg}) begin
                since = r.now_ms - press_t0[b];
                lng = since > {16'd0, long_cfg};
                p.press_kind = lng ? PRESS_LONG : PRESS_SHORT;
                p.press_button = b;
                btn_held[b] = 1'b0;
                last_edge[b] = r.now_ms;
                press_t0[b] = 32'd0;
                case (cur_mode)
                    MODE_TUNE: begin
                        if (b == BTN_USER) begin
                            if (lng) cur_mode = MODE_CLOCK;
                        end else if (!tune_hr) begin
                            if (b == BTN_LEFT && lng) tune_hr = 1'b1;
                            else if (b == BTN_LEFT) alarm_at = alarm_at - MINUTE_MS;
                            else if (!lng) alarm_at = alarm_at + MINUTE_MS;
                        end else begin
                            if (b == BTN_RIGHT && lng) tune_hr = 1'b0;
                            else if (b == BTN_LEFT && !lng) alarm_at = alarm_at - HOUR_MS;
                            else if (b == BTN_RIGHT && !lng) alarm_at = alarm_at + HOUR_MS;
                        end
                    end
                    MODE_ALARM: begin
                        p.stop_alarm = 1'b1;
                        if (!lng) begin
                            if (b == BTN_LEFT) alarm_at = alarm_at + short_snooze_cfg;
                            else if (b == BTN_RIGHT) alarm_at = alarm_at + long_snooze_cfg;
                            cur_mode = MODE_CLOCK;
                        end
                    end
                    default: begin
                        if (b == BTN_USER && lng) begin
                            alarm_at = 32'd0;
                            cur_mode = MODE_TUNE;
                        end else begin
                            cur_mode = MODE_CLOCK;
                        end
                    end
                endcase
            end
        end
        p.mode = cur_mode;
        p.hour_select = tune_hr;
        p.alarm_ms = alarm_at;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    task automatic push_event(input req_t r);
        event_queue.push_back(r);
        items_queued++;
    endtask

    task automatic queue_edge(input logic [1:0] b, input logic rise, input int dt);
        req_t r;
        ms_clock = ms_clock + dt;
        r.req_type = REQ_BUTTON;
        r.which_button = b;
        r.rising = rise;
        r.now_ms = ms_clock;
        push_event(r);
    endtask

    task automatic queue_press(input logic [1:0] b, input logic lng);
        int lo;
        int hi;
        int dur;
        lo = int'(debounce_cfg) + 1;
        if (lng) begin
            dur = ((debounce_cfg > long_cfg) ? int'(debounce_cfg) : int'(long_cfg))
                  + 1 + $urandom_range(0, 400);
        end else begin
            hi = (int'(long_cfg) > lo) ? int'(long_cfg) : lo;
            dur = $urandom_range(lo, hi);
        end
        queue_edge(b, 1'b1, lo + $urandom_range(0, 100));
        queue_edge(b, 1'b0, dur);
    endtask

    task automatic queue_alarm();
        req_t r;
        ms_clock = ms_clock + $urandom_range(0, 1000);
        r.req_type = REQ_ALARM;
        r.which_button = 2'($urandom_range(0, 3));
        r.rising = 1'($urandom_range(0, 1));
        r.now_ms = ms_clock;
        push_event(r);
    endtask

    task automatic queue_random_events(input int n);
        int   target;
        int   pick;
        req_t r;
        target = items_queued + n;
        while (items_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_press(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
            end else if (pick < 65) begin
                queue_alarm();
            end else if (pick < 75) begin
                queue_edge(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, debounce_cfg));
            end else if (pick < 85) begin
                queue_edge(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 2 * debounce_cfg + long_cfg + 1));
            end else begin
                r.req_type = 1'($urandom_range(0, 1));
                r.which_button = 2'($urandom_range(0, 3));
                r.rising = 1'($urandom_range(0, 1));
                r.now_ms = $urandom();
                ms_clock = r.now_ms;
                push_event(r);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DEBOUNCE:     debounce_cfg = val[15:0];
            CFG_LONG_PRESS:   long_cfg = val[15:0];
            CFG_SHORT_SNOOZE: short_snooze_cfg = val;
            CFG_LONG_SNOOZE:  long_snooze_cfg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] deb, input logic [15:0] lp,
                              input logic [31:0] ss, input logic [31:0] ls);
        write_reg(CFG_DEBOUNCE, {16'd0, deb});
        write_reg(CFG_LONG_PRESS, {16'd0, lp});
        write_reg(CFG_SHORT_SNOOZE, ss);
        write_reg(CFG_LONG_SNOOZE, ls);
        settings_count++;
    endtask

    task automatic settle();
        @(posedge aclk);
        while (event_queue.size() != 0 || s_valid || panel_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || req_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (event_queue.size() != 0 && send_idle_pct != 0 &&
                         $urandom_range(0, 99) < send_idle_pct) begin
                send_gap = $urandom_range(1, 9) - 1;
                s_valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
                s_data <= event_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            hold_cnt = $urandom_range(1, 9) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // accepted requests feed the predictor
    always @(posedge aclk) begin
        req_taken = aresetn && s_valid && s_ready;
        if (req_taken)
            panel_due.push_back(expected_panel(s_data));
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (panel_due.size() == 0) begin
                $error("unexpected result: mode %0d alarm_ms %0d", m_data.mode,
                       m_data.alarm_ms);
                mismatches++;
            end else begin
                want = panel_due.pop_front();
                check_field("mode", 32'(want.mode), 32'(m_data.mode));
                check_field("hour_select", 32'(want.hour_select), 32'(m_data.hour_select));
                check_field("alarm_ms", want.alarm_ms, m_data.alarm_ms);
                check_field("press_kind", 32'(want.press_kind), 32'(m_data.press_kind));
                check_field("press_button", 32'(want.press_button),
                            32'(m_data.press_button));
                check_field("stop_alarm", 32'(want.stop_alarm), 32'(m_data.stop_alarm));
                if (want.press_kind == PRESS_SHORT) short_seen++;
                if (want.press_kind == PRESS_LONG) long_seen++;
                if (want.stop_alarm) stop_seen++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed sequence at reset defaults
        settings_count = 1;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        queue_press(BTN_USER, 1'b1);
        queue_press(BTN_LEFT, 1'b0);
        queue_edge(BTN_RIGHT, 1'b1, 100);
        queue_edge(BTN_RIGHT, 1'b0, int'(LONG_PRESS_RST));
        queue_press(BTN_LEFT, 1'b1);
        queue_press(BTN_RIGHT, 1'b0);
        queue_press(BTN_USER, 1'b1);
        queue_press(BTN_USER, 1'b1);
        queue_press(BTN_RIGHT, 1'b1);
        queue_alarm();
        queue_press(BTN_LEFT, 1'b1);
        queue_press(BTN_RIGHT, 1'b0);
        queue_alarm();
        queue_press(BTN_USER, 1'b0);
        queue_edge(BTN_USER, 1'b0, 100);
        queue_edge(BTN_NONE, 1'b1, 10);
        queue_edge(BTN_LEFT, 1'b1, 100);
        queue_edge(BTN_LEFT, 1'b0, int'(DEBOUNCE_RST));
        queue_edge(BTN_LEFT, 1'b1, 10);
        queue_edge(BTN_LEFT, 1'b0, 1);
        settle();

        // defaults with a long receiver stall
        send_idle_pct = 30;
        recv_idle_pct = 30;
        long_hold_req = 1'b1;
        queue_random_events(280);
        settle();

        set_config(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 40;
        queue_random_events(200);
        settle();

        set_config(16'hFFFF, 16'd0, 32'd0, 32'hFFFF_FFFF);
        ms_clock = 32'hFFFF_0000;
        send_idle_pct = 40;
        recv_idle_pct = 0;
        queue_random_events(150);
        settle();

        set_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 1500)),
                   $urandom(), $urandom());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_events(250);
        settle();

        repeat (5) @(posedge aclk);
        $display("checked %0d results from %0d requests under %0d register settings",
                 results_seen, items_queued, settings_count);
        $display("presses seen: %0d short, %0d long, %0d alarm stops",
                 short_seen, long_seen, stop_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== alarm_button_controller.f =====
rtl/core/abc_pkg.sv
rtl/core/alarm_button_controller.sv
dv/testbench.sv
